FILE: hw/rtl/dsc_pkg.sv
// Shared types and constants for the datagram sequence checker.
// Depends on nothing; imported by the top level and by its checker.
package dsc_pkg;

    // Result codes carried on the status output
    typedef enum logic [2:0] {
        ST_IN_ORDER  = 3'd0,
        ST_LOSS      = 3'd1,
        ST_OUT_ORDER = 3'd2,
        ST_DUPLICATE = 3'd3,
        ST_INVALID   = 3'd4,
        ST_STOP      = 3'd5,
        ST_RANGE     = 3'd6,
        ST_HALTED    = 3'd7
    } t_status;

    // Number parser phase, one-hot
    typedef enum logic [4:0] {
        PH_TAG    = 5'b00001,
        PH_SPACE  = 5'b00010,
        PH_SIGNED = 5'b00100,
        PH_DIGITS = 5'b01000,
        PH_DONE   = 5'b10000
    } t_phase;

    // Outcome of parsing, known at the final byte
    typedef enum logic [1:0] {
        K_STOP    = 2'd0,
        K_INVALID = 2'd1,
        K_RANGE   = 2'd2,
        K_CHECK   = 2'd3
    } t_kind;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_S     = 8'h53;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_Q     = 8'h51;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_O     = 8'h4F;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_BAR   = 8'h7C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [31:0] INT32_MAX = 32'h7FFF_FFFF;

    // Character of the "SEQ:" tag at a position
    function automatic logic [7:0] tag_char(input logic [1:0] idx);
        case (idx)
            2'd0: tag_char = CH_S;
            2'd1: tag_char = CH_E;
            2'd2: tag_char = CH_Q;
            default: tag_char = CH_COLON;
        endcase
    endfunction

    // Character of the "STOP" command at a position
    function automatic logic [7:0] stop_char(input logic [1:0] idx);
        case (idx)
            2'd0: stop_char = CH_S;
            2'd1: stop_char = CH_T;
            2'd2: stop_char = CH_O;
            default: stop_char = CH_P;
        endcase
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

endpackage

FILE: hw/rtl/datagram_sequence_checker.sv
// Datagram sequence checker top level: byte parser, seen-map memory and result register.
// Depends on dsc_pkg.
//
// Takes one datagram byte per cycle when the input is not stalled, no gaps required;
// each datagram gives exactly one result transaction, through stage 1, stage 2 and
// the result register after its final byte. The text is cut at the first NUL byte
// and after BUFFER_BYTES-1 bytes. The first "SEQ:" and the first '|' after it frame
// a decimal number (leading whitespace, optional sign, digits, int32 range). A
// datagram that is exactly "STOP" halts the block until reset: every later datagram
// reports status halted. Valid numbers inside 0..SEQ_SPACE-1 are looked up in a
// one-bit seen map held in a single synchronous memory; stage 1 reads it and stage 2
// modifies and writes it back, with a forward path for two successive datagrams that
// name the same number. Sustained rate is one byte per cycle, set by the per-byte
// parser (multiply-by-ten, add and overflow compare). Apart from the seen-map clear
// after reset, the input stalls only when the result pipeline is full and the output
// is stalled. After reset the seen map is cleared one entry a cycle, all SEQ_SPACE
// entries; the input stalls until the clear is done while first_expected writes are
// still taken. Writing first_expected loads the expected number at once; write it
// only while the block is idle.
module datagram_sequence_checker #(
    parameter int SEQ_SPACE    = 1024,
    parameter int BUFFER_BYTES = 256,
    localparam int SEQ_W = $clog2(SEQ_SPACE),
    localparam int EXP_W = $clog2(SEQ_SPACE + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration write
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [EXP_W-1:0] i_first_expected,
    // datagram bytes
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [7:0]       i_data_byte,
    input  logic             i_end_of_datagram,
    // results
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [2:0]       o_status,
    output logic [SEQ_W-1:0] o_sequence_value,
    output logic [EXP_W-1:0] o_expected_before
);
    import dsc_pkg::*;

    localparam int CNT_W = $clog2(BUFFER_BYTES);
    localparam logic [CNT_W-1:0] CNT_LIMIT  = CNT_W'(BUFFER_BYTES - 1);
    localparam logic [CNT_W-1:0] CNT_STOP   = CNT_W'(4);
    localparam logic [SEQ_W-1:0] LAST_ENTRY = SEQ_W'(SEQ_SPACE - 1);
    localparam logic [EXP_W-1:0] EXP_RESET  = EXP_W'(1);

    // ---------------------------------------------------------------
    // Flow control: each stage moves when the stage ahead is free.
    // ---------------------------------------------------------------
    logic r_out_valid;
    logic r_s1_valid;
    logic r_s2_valid;
    logic r_clr_busy;

    logic w_out_free;
    logic w_s2_adv;
    logic w_s1_adv;
    logic w_in_accept;
    logic w_commit;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_s2_adv    = !r_s2_valid || w_out_free;
    assign w_s1_adv    = !r_s1_valid || w_s2_adv;
    assign w_commit    = r_s2_valid && w_out_free;
    assign o_in_stall  = r_clr_busy || !w_s1_adv;
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // ---------------------------------------------------------------
    // Per-datagram parser
    // ---------------------------------------------------------------
    logic             r_truncated, n_truncated;
    logic [CNT_W-1:0] r_byte_cnt,  n_byte_cnt;
    logic             r_stop_miss, n_stop_miss;
    logic [1:0]       r_tag_prog,  n_tag_prog;
    t_phase           r_phase,     n_phase;
    logic             r_neg,       n_neg;
    logic [31:0]      r_acc,       n_acc;
    logic             r_ovf,       n_ovf;
    logic             r_saw_digit, n_saw_digit;
    logic             r_saw_sep,   n_saw_sep;

    logic             w_is_digit;
    logic [35:0]      w_acc_next;
    logic [35:0]      w_acc_limit;
    t_kind            w_kind;
    logic [SEQ_W-1:0] w_value;

    assign w_is_digit  = (i_data_byte >= CH_ZERO) && (i_data_byte <= CH_NINE);
    // acc * 10 + digit as two shifts and two adds
    assign w_acc_next  = (36'(r_acc) << 3) + (36'(r_acc) << 1)
                       + 36'(i_data_byte - CH_ZERO);
    assign w_acc_limit = 36'(INT32_MAX) + 36'(r_neg);

    always_comb begin
        n_truncated = r_truncated;
        n_byte_cnt  = r_byte_cnt;
        n_stop_miss = r_stop_miss;
        n_tag_prog  = r_tag_prog;
        n_phase     = r_phase;
        n_neg       = r_neg;
        n_acc       = r_acc;
        n_ovf       = r_ovf;
        n_saw_digit = r_saw_digit;
        n_saw_sep   = r_saw_sep;
        w_kind      = K_CHECK;

        if (w_in_accept && !r_truncated) begin
            if (i_data_byte == CH_NUL || r_byte_cnt >= CNT_LIMIT) begin
                n_truncated = 1'b1;
            end else begin
                if (r_byte_cnt < CNT_STOP) begin
                    if (i_data_byte != stop_char(r_byte_cnt[1:0])) begin
                        n_stop_miss = 1'b1;
                    end
                end else begin
                    n_stop_miss = 1'b1;
                end
                n_byte_cnt = r_byte_cnt + 1'b1;

                if (!r_saw_sep) begin
                    if (r_phase == PH_TAG) begin
                        if (i_data_byte == tag_char(r_tag_prog)) begin
                            n_tag_prog = r_tag_prog + 1'b1;
                            if (r_tag_prog == 2'd3) begin
                                n_phase = PH_SPACE;
                            end
                        end else begin
                            n_tag_prog = (i_data_byte == CH_S) ? 2'd1 : 2'd0;
                        end
                    end else if (i_data_byte == CH_BAR) begin
                        n_saw_sep = 1'b1;
                    end else begin
                        case (r_phase)
                            PH_SPACE: begin
                                if (is_space(i_data_byte)) begin
                                    n_phase = PH_SPACE;
                                end else if (i_data_byte == CH_PLUS ||
                                             i_data_byte == CH_MINUS) begin
                                    n_neg   = (i_data_byte == CH_MINUS);
                                    n_phase = PH_SIGNED;
                                end else if (w_is_digit) begin
                                    n_saw_digit = 1'b1;
                                    if (w_acc_next > w_acc_limit) begin
                                        n_ovf = 1'b1;
                                    end else begin
                                        n_acc = w_acc_next[31:0];
                                    end
                                    n_phase = PH_DIGITS;
                                end else begin
                                    n_phase = PH_DONE;
                                end
                            end
                            PH_SIGNED, PH_DIGITS: begin
                                if (w_is_digit) begin
                                    n_saw_digit = 1'b1;
                                    if (!r_ovf) begin
                                        if (w_acc_next > w_acc_limit) begin
                                            n_ovf = 1'b1;
                                        end else begin
                                            n_acc = w_acc_next[31:0];
                                        end
                                    end
                                    n_phase = PH_DIGITS;
                                end else begin
                                    n_phase = PH_DONE;
                                end
                            end
                            default: begin
                                n_phase = r_phase;
                            end
                        endcase
                    end
                end
            end
        end

        // Classify the datagram from the state it ends with
        if (!n_stop_miss && n_byte_cnt == CNT_STOP) begin
            w_kind = K_STOP;
        end else if (!n_saw_sep || !n_saw_digit || n_ovf ||
                     (n_neg && n_acc == 32'd1)) begin
            w_kind = K_INVALID;
        end else if (n_acc != 32'd0 && (n_neg || n_acc >= 32'(SEQ_SPACE))) begin
            w_kind = K_RANGE;
        end else begin
            w_kind = K_CHECK;
        end
        // Capture the number before the per-datagram state is dropped
        w_value = n_acc[SEQ_W-1:0];

        // Drop all per-datagram state after the final byte
        if (w_in_accept && i_end_of_datagram) begin
            n_truncated = 1'b0;
            n_byte_cnt  = '0;
            n_stop_miss = 1'b0;
            n_tag_prog  = 2'd0;
            n_phase     = PH_TAG;
            n_neg       = 1'b0;
            n_acc       = '0;
            n_ovf       = 1'b0;
            n_saw_digit = 1'b0;
            n_saw_sep   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_truncated <= 1'b0;
            r_byte_cnt  <= '0;
            r_stop_miss <= 1'b0;
            r_tag_prog  <= 2'd0;
            r_phase     <= PH_TAG;
            r_neg       <= 1'b0;
            r_acc       <= '0;
            r_ovf       <= 1'b0;
            r_saw_digit <= 1'b0;
            r_saw_sep   <= 1'b0;
        end else begin
            r_truncated <= n_truncated;
            r_byte_cnt  <= n_byte_cnt;
            r_stop_miss <= n_stop_miss;
            r_tag_prog  <= n_tag_prog;
            r_phase     <= n_phase;
            r_neg       <= n_neg;
            r_acc       <= n_acc;
            r_ovf       <= n_ovf;
            r_saw_digit <= n_saw_digit;
            r_saw_sep   <= n_saw_sep;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: parsed outcome waits here while the seen map is read.
    // Stage 2: read data arrives; decide, write back, load the output.
    // ---------------------------------------------------------------
    t_kind            r_s1_kind;
    logic [SEQ_W-1:0] r_s1_value;
    t_kind            r_s2_kind;
    logic [SEQ_W-1:0] r_s2_value;
    logic             r_rd_data;
    logic             r_fwd;

    logic [EXP_W-1:0] r_expected;
    logic             r_halted;
    logic [SEQ_W-1:0] r_clr_idx;

    logic             r_seen_mem [SEQ_SPACE];

    logic             w_seen;
    logic             w_mark;
    t_status          w_status;
    logic [SEQ_W-1:0] w_seq_out;
    logic [EXP_W-1:0] w_value_ext;

    assign w_seen      = r_rd_data || r_fwd;
    assign w_value_ext = EXP_W'(r_s2_value);
    assign w_mark      = !r_halted && (r_s2_kind == K_CHECK) && !w_seen;

    always_comb begin
        w_status  = ST_INVALID;
        w_seq_out = '0;
        if (r_halted) begin
            w_status = ST_HALTED;
        end else begin
            case (r_s2_kind)
                K_STOP:    w_status = ST_STOP;
                K_INVALID: w_status = ST_INVALID;
                K_RANGE:   w_status = ST_RANGE;
                K_CHECK: begin
                    w_seq_out = r_s2_value;
                    if (w_seen) begin
                        w_status = ST_DUPLICATE;
                    end else if (w_value_ext > r_expected) begin
                        w_status = ST_LOSS;
                    end else if (w_value_ext < r_expected) begin
                        w_status = ST_OUT_ORDER;
                    end else begin
                        w_status = ST_IN_ORDER;
                    end
                end
                default: w_status = ST_INVALID;
            endcase
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_halted    <= 1'b0;
            r_expected  <= EXP_RESET;
            r_clr_busy  <= 1'b1;
            r_clr_idx   <= '0;
        end else begin
            if (w_s1_adv) begin
                r_s1_valid <= w_in_accept && i_end_of_datagram;
            end
            if (w_s2_adv) begin
                r_s2_valid <= r_s1_valid;
            end
            if (w_out_free) begin
                r_out_valid <= r_s2_valid;
            end
            if (w_commit && !r_halted && r_s2_kind == K_STOP) begin
                r_halted <= 1'b1;
            end
            if (i_cfg_valid) begin
                r_expected <= i_first_expected;
            end else if (w_commit && w_mark) begin
                r_expected <= w_value_ext + 1'b1;
            end
            if (r_clr_busy) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == LAST_ENTRY) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    // Payload registers and the seen-map memory
    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_s1_kind  <= w_kind;
            r_s1_value <= w_value;
        end
        if (w_s2_adv) begin
            r_s2_kind  <= r_s1_kind;
            r_s2_value <= r_s1_value;
            r_rd_data  <= r_seen_mem[r_s1_value];
            // The write below lands after this read: forward it
            r_fwd      <= w_commit && w_mark && (r_s2_value == r_s1_value);
        end
        if (r_clr_busy) begin
            r_seen_mem[r_clr_idx] <= 1'b0;
        end else if (w_commit && w_mark) begin
            r_seen_mem[r_s2_value] <= 1'b1;
        end
    end

    // Result register
    t_status          r_out_status;
    logic [SEQ_W-1:0] r_out_seq;
    logic [EXP_W-1:0] r_out_exp;

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_status <= w_status;
            r_out_seq    <= w_seq_out;
            r_out_exp    <= r_expected;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_status          = r_out_status;
    assign o_sequence_value  = r_out_seq;
    assign o_expected_before = r_out_exp;

endmodule

FILE: hw/rtl/dsc_checker.sv
// Port-level assertions for the datagram sequence checker, bound to its top level.
// Depends on dsc_pkg and on datagram_sequence_checker.
module dsc_checker #(
    parameter int SEQ_W = 10,
    parameter int EXP_W = 11
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_in_stall,
    input logic             o_out_valid,
    input logic             i_out_stall,
    input logic [2:0]       o_status,
    input logic [SEQ_W-1:0] o_sequence_value,
    input logic [EXP_W-1:0] o_expected_before
);
    import dsc_pkg::*;

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status) &&
            $stable(o_sequence_value) && $stable(o_expected_before))
        else $error("result changed while stalled");

    // Seen-map clearing keeps the input stalled right after reset
    a_clear_stall: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> o_in_stall)
        else $error("input not stalled during seen-map clear");

    // Statuses without a number carry zero
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_INVALID || o_status == ST_STOP ||
            o_status == ST_RANGE || o_status == ST_HALTED)
            |-> o_sequence_value == '0)
        else $error("sequence value not zero for a status without a number");

    // In order means the number equals the expected one
    a_in_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_IN_ORDER
            |-> EXP_W'(o_sequence_value) == o_expected_before)
        else $error("in-order status with a number other than expected");

    // Loss lies above the expected number, out of order below it
    a_order_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_LOSS || o_status == ST_OUT_ORDER)
            |-> ((o_status == ST_LOSS) ==
                 (EXP_W'(o_sequence_value) > o_expected_before)) &&
                (EXP_W'(o_sequence_value) != o_expected_before))
        else $error("loss or out-of-order status on the wrong side");

endmodule

bind datagram_sequence_checker dsc_checker #(
    .SEQ_W(SEQ_W),
    .EXP_W(EXP_W)
) u_dsc_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_in_stall        (o_in_stall),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_status          (o_status),
    .o_sequence_value  (o_sequence_value),
    .o_expected_before (o_expected_before)
);
